// ===== hdl/gfba_pkg.sv =====
// Types and constants used by the grouped free-block allocator top level.
package gfba_pkg;

  typedef enum logic [1:0] {
    CMD_FORMAT  = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] amount;
    logic [9:0] block_number;
  } in_t;

  typedef struct packed {
    logic [9:0] granted_block;
    logic       status;
    logic [4:0] head_count;
    logic       last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMT,
    ST_PUSH,
    ST_SPILL,
    ST_POP_RD,
    ST_POP_CHK,
    ST_LOAD_SZ,
    ST_LOAD_CP,
    ST_RB_RD,
    ST_RB_WAIT,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/grouped_free_block_allocator.sv =====
// Top level of the grouped free-block allocator: sequencer and its four memories.
//
// This block keeps a classic grouped free list of disk block numbers. A head stack of up
// to GROUP_SIZE free numbers sits in a small RAM; every further group of free numbers is
// stored in a group RAM, in the row of the block that links to it, with its size in a
// size RAM. Format chains blocks FIRST_FREE+1 up to NUM_BLOCKS-1, one list entry per
// cycle. Allocate pops up to MAX_AMOUNT blocks; when the head empties, the group of the
// block just popped is copied into the head. Each grant then leaves as its own result
// transfer. If the list runs dry or an end mark is reached, the blocks already taken are
// released again in reverse order and one result with status no_space is returned.
// Release pushes one block, after first spilling a full head into the released block.
// Items are handled one at a time, since every step reads what the step before wrote
// through the single read port of each memory; the input is stalled while an item is
// in progress. Results pass through an output register, so a stalled output only holds
// the sequencer at the point where it has a new result to hand over.
module grouped_free_block_allocator
  import gfba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024,
  parameter int GROUP_SIZE = 16,
  parameter int FIRST_FREE = 4,
  parameter int MAX_AMOUNT = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Entry width holds any block number plus the end mark NUM_BLOCKS.
  localparam int EW  = $clog2(NUM_BLOCKS + 1);
  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int DW  = $clog2(GROUP_SIZE + 1);
  localparam int HAW = $clog2(GROUP_SIZE);
  localparam int GAW = $clog2(NUM_BLOCKS * GROUP_SIZE);
  localparam int AW  = $clog2(MAX_AMOUNT + 1);
  localparam int PAW = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT) : 1;
  localparam int HCW = $bits(out_data.head_count);
  localparam int GBW = $bits(out_data.granted_block);

  state_t state_r, state_nxt;

  logic [DW-1:0]  depth_r, depth_nxt;
  logic [AW-1:0]  n_r, n_nxt;
  logic [AW-1:0]  got_r, got_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  logic           fail_r, fail_nxt;
  logic [BW-1:0]  pb_r, pb_nxt;
  logic [GAW-1:0] base_r, base_nxt;
  logic [DW-1:0]  ci_r, ci_nxt;
  logic [DW-1:0]  sz_r, sz_nxt;
  logic           d0_r, d0_nxt;
  logic [DW-1:0]  si_r, si_nxt;
  logic [EW-1:0]  fb_r, fb_nxt;
  logic [DW-1:0]  fi_r, fi_nxt;
  logic           first_r, first_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_data_r, out_data_nxt;

  // Memory ports.
  logic           hd_we;
  logic [HAW-1:0] hd_waddr, hd_raddr;
  logic [EW-1:0]  hd_wdata, hd_rdata;
  logic           ge_we;
  logic [GAW-1:0] ge_waddr, ge_raddr;
  logic [EW-1:0]  ge_wdata, ge_rdata;
  logic           gs_we;
  logic [BW-1:0]  gs_waddr, gs_raddr;
  logic [DW-1:0]  gs_wdata, gs_rdata;
  logic           pg_we;
  logic [PAW-1:0] pg_waddr, pg_raddr;
  logic [BW-1:0]  pg_wdata, pg_rdata;

  // Shared conditions.
  logic           out_free;
  logic           pop_bad;
  logic [DW-1:0]  sz_clamped;
  logic [31:0]    fmt_rem;
  logic [DW-1:0]  fmt_s;
  logic           fmt_done;
  logic           fmt_last;
  logic           blk_ok;
  logic [AW-1:0]  amt_n;
  logic [AW-1:0]  k_inc;

  assign out_free   = !out_valid_r || !out_stall;
  assign pop_bad    = (hd_rdata == '0) || (32'(hd_rdata) >= NUM_BLOCKS);
  assign sz_clamped = (32'(gs_rdata) > GROUP_SIZE) ? DW'(GROUP_SIZE) : gs_rdata;
  assign fmt_rem    = 32'(NUM_BLOCKS) - 32'(fb_r);
  assign fmt_s      = (fmt_rem > 32'(GROUP_SIZE)) ? DW'(GROUP_SIZE) : DW'(fmt_rem);
  assign fmt_done   = (32'(fb_r) >= NUM_BLOCKS);
  assign fmt_last   = (fi_r == (fmt_s - DW'(1)));
  assign blk_ok     = (32'(in_data.block_number) < NUM_BLOCKS);
  assign k_inc      = k_r + AW'(1);

  always_comb begin
    if (in_data.amount == '0) begin
      amt_n = AW'(1);
    end else if (32'(in_data.amount) > MAX_AMOUNT) begin
      amt_n = AW'(MAX_AMOUNT);
    end else begin
      amt_n = AW'(in_data.amount);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_data.command))
            CMD_FORMAT:  state_nxt = ST_FMT;
            CMD_ALLOC:   state_nxt = ST_POP_RD;
            CMD_RELEASE: state_nxt = blk_ok ? ST_PUSH : ST_DONE;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FMT: begin
        if (fmt_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_PUSH: begin
        if (32'(depth_r) < GROUP_SIZE) begin
          state_nxt = fail_r ? ST_RB_RD : ST_DONE;
        end else begin
          state_nxt = ST_SPILL;
        end
      end
      ST_SPILL: begin
        if (32'(si_r) == GROUP_SIZE) begin
          state_nxt = fail_r ? ST_RB_RD : ST_DONE;
        end
      end
      ST_POP_RD: begin
        priority if (got_r == n_r) begin
          state_nxt = ST_EMIT_RD;
        end else if (depth_r == '0) begin
          state_nxt = ST_RB_RD;
        end else begin
          state_nxt = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        priority if (pop_bad) begin
          state_nxt = ST_RB_RD;
        end else if (depth_r == DW'(1)) begin
          state_nxt = ST_LOAD_SZ;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_LOAD_SZ: state_nxt = ST_LOAD_CP;
      ST_LOAD_CP: begin
        if (ci_r == sz_r) begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_RB_RD:   state_nxt = (got_r == '0) ? ST_DONE : ST_RB_WAIT;
      ST_RB_WAIT: state_nxt = ST_PUSH;
      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_WR;
        end
      end
      ST_EMIT_WR: state_nxt = (k_inc == got_r) ? ST_IDLE : ST_EMIT_RD;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates and memory controls.
  always_comb begin
    depth_nxt     = depth_r;
    n_nxt         = n_r;
    got_nxt       = got_r;
    k_nxt         = k_r;
    fail_nxt      = fail_r;
    pb_nxt        = pb_r;
    base_nxt      = base_r;
    ci_nxt        = ci_r;
    sz_nxt        = sz_r;
    d0_nxt        = d0_r;
    si_nxt        = si_r;
    fb_nxt        = fb_r;
    fi_nxt        = fi_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    hd_we    = 1'b0;
    hd_waddr = '0;
    hd_wdata = '0;
    hd_raddr = '0;
    ge_we    = 1'b0;
    ge_waddr = '0;
    ge_wdata = '0;
    ge_raddr = '0;
    gs_we    = 1'b0;
    gs_waddr = '0;
    gs_wdata = '0;
    gs_raddr = '0;
    pg_we    = 1'b0;
    pg_waddr = '0;
    pg_wdata = '0;
    pg_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt    = amt_n;
          got_nxt  = '0;
          k_nxt    = '0;
          fail_nxt = 1'b0;
          pb_nxt   = BW'(in_data.block_number);
          if (cmd_t'(in_data.command) == CMD_FORMAT) begin
            fb_nxt    = EW'(FIRST_FREE);
            fi_nxt    = '0;
            first_nxt = 1'b1;
            depth_nxt = '0;
          end
        end
      end
      ST_FMT: begin
        if (!fmt_done) begin
          // The first group goes to the head stack, the rest to the row of their link.
          if (first_r) begin
            hd_we    = 1'b1;
            hd_waddr = HAW'(fi_r);
            hd_wdata = EW'(32'(fb_r) + 32'(fmt_s) - 32'(fi_r));
          end else begin
            ge_we    = 1'b1;
            ge_waddr = GAW'(32'(fb_r) * 32'(GROUP_SIZE) + 32'(fi_r));
            ge_wdata = EW'(32'(fb_r) + 32'(fmt_s) - 32'(fi_r));
          end
          if (fmt_last) begin
            if (first_r) begin
              depth_nxt = fmt_s;
            end else begin
              gs_we    = 1'b1;
              gs_waddr = BW'(fb_r);
              gs_wdata = fmt_s;
            end
            first_nxt = 1'b0;
            fb_nxt    = EW'(32'(fb_r) + 32'(fmt_s));
            fi_nxt    = '0;
          end else begin
            fi_nxt = fi_r + DW'(1);
          end
        end
      end
      ST_PUSH: begin
        if (32'(depth_r) < GROUP_SIZE) begin
          hd_we     = 1'b1;
          hd_waddr  = HAW'(depth_r);
          hd_wdata  = EW'(pb_r);
          depth_nxt = depth_r + DW'(1);
        end else begin
          base_nxt = GAW'(32'(pb_r) * 32'(GROUP_SIZE));
          si_nxt   = '0;
        end
      end
      ST_SPILL: begin
        // Read head entry si while writing the entry read in the previous cycle.
        hd_raddr = HAW'(si_r);
        if (si_r != '0) begin
          ge_we    = 1'b1;
          ge_waddr = base_r + GAW'(si_r) - GAW'(1);
          ge_wdata = hd_rdata;
        end
        if (32'(si_r) == GROUP_SIZE) begin
          gs_we     = 1'b1;
          gs_waddr  = pb_r;
          gs_wdata  = DW'(GROUP_SIZE);
          hd_we     = 1'b1;
          hd_waddr  = '0;
          hd_wdata  = EW'(pb_r);
          depth_nxt = DW'(1);
        end else begin
          si_nxt = si_r + DW'(1);
        end
      end
      ST_POP_RD: begin
        if (got_r == n_r) begin
          k_nxt = '0;
        end else if (depth_r == '0) begin
          fail_nxt = 1'b1;
        end else begin
          hd_raddr = HAW'(depth_r - DW'(1));
        end
      end
      ST_POP_CHK: begin
        if (pop_bad) begin
          fail_nxt = 1'b1;
        end else begin
          pg_we     = 1'b1;
          pg_waddr  = PAW'(got_r);
          pg_wdata  = BW'(hd_rdata);
          got_nxt   = got_r + AW'(1);
          depth_nxt = depth_r - DW'(1);
          gs_raddr  = BW'(hd_rdata);
          base_nxt  = GAW'(32'(hd_rdata) * 32'(GROUP_SIZE));
        end
      end
      ST_LOAD_SZ: begin
        // A short group gets a zero end mark at the bottom of the head.
        sz_nxt = sz_clamped;
        ci_nxt = '0;
        if (32'(sz_clamped) < GROUP_SIZE) begin
          hd_we    = 1'b1;
          hd_waddr = '0;
          hd_wdata = '0;
          d0_nxt   = 1'b1;
        end else begin
          d0_nxt = 1'b0;
        end
      end
      ST_LOAD_CP: begin
        ge_raddr = base_r + GAW'(ci_r);
        if (ci_r != '0) begin
          hd_we    = 1'b1;
          hd_waddr = HAW'(DW'(d0_r) + ci_r - DW'(1));
          hd_wdata = ge_rdata;
        end
        if (ci_r == sz_r) begin
          depth_nxt = DW'(d0_r) + sz_r;
        end else begin
          ci_nxt = ci_r + DW'(1);
        end
      end
      ST_RB_RD: begin
        if (got_r != '0) begin
          pg_raddr = PAW'(got_r - AW'(1));
          got_nxt  = got_r - AW'(1);
        end
      end
      ST_RB_WAIT: begin
        pb_nxt = pg_rdata;
      end
      ST_EMIT_RD: begin
        pg_raddr = PAW'(k_r);
      end
      ST_EMIT_WR: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.granted_block = GBW'(pg_rdata);
        out_data_nxt.status        = STATUS_OK;
        out_data_nxt.head_count    = HCW'(depth_r);
        out_data_nxt.last          = (k_inc == got_r);
        k_nxt                      = k_inc;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.granted_block = '0;
          out_data_nxt.status        = fail_r ? STATUS_NO_SPACE : STATUS_OK;
          out_data_nxt.head_count    = HCW'(depth_r);
          out_data_nxt.last          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      fail_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      fail_r      <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    got_r      <= got_nxt;
    k_r        <= k_nxt;
    pb_r       <= pb_nxt;
    base_r     <= base_nxt;
    ci_r       <= ci_nxt;
    sz_r       <= sz_nxt;
    d0_r       <= d0_nxt;
    si_r       <= si_nxt;
    fb_r       <= fb_nxt;
    fi_r       <= fi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Head stack of free block numbers, bottom at address zero.
  gfba_ram #(.WIDTH(EW), .DEPTH(GROUP_SIZE)) u_head (
    .clk  (clk),
    .we   (hd_we),
    .waddr(hd_waddr),
    .wdata(hd_wdata),
    .raddr(hd_raddr),
    .rdata(hd_rdata)
  );

  // Group rows, GROUP_SIZE entries per block.
  gfba_ram #(.WIDTH(EW), .DEPTH(NUM_BLOCKS * GROUP_SIZE)) u_group (
    .clk  (clk),
    .we   (ge_we),
    .waddr(ge_waddr),
    .wdata(ge_wdata),
    .raddr(ge_raddr),
    .rdata(ge_rdata)
  );

  // Group size per block.
  gfba_ram #(.WIDTH(DW), .DEPTH(NUM_BLOCKS)) u_size (
    .clk  (clk),
    .we   (gs_we),
    .waddr(gs_waddr),
    .wdata(gs_wdata),
    .raddr(gs_raddr),
    .rdata(gs_rdata)
  );

  // Blocks granted so far in the current allocate.
  gfba_ram #(.WIDTH(BW), .DEPTH(MAX_AMOUNT)) u_pending (
    .clk  (clk),
    .we   (pg_we),
    .waddr(pg_waddr),
    .wdata(pg_wdata),
    .raddr(pg_raddr),
    .rdata(pg_rdata)
  );

endmodule

// ===== hdl/gfba_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module gfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
